// ===== rtl/sbp_pkg.sv =====
package sbp_pkg;

  localparam logic [16:0] Q_ONE     = 17'd65536;
  localparam logic [16:0] LX        = 17'd27487;
  localparam logic [16:0] LY        = 17'd37958;
  localparam logic [16:0] LZ        = 17'd45811;
  localparam logic [16:0] HX        = 17'd14911;
  localparam logic [16:0] HY        = 17'd20591;
  localparam logic [16:0] HZ        = 17'd60404;
  localparam logic [16:0] DIFF_BIAS = 17'd19661;
  localparam logic [16:0] DIFF_GAIN = 17'd45875;
  localparam logic [16:0] SPEC_BIAS = 17'd5243;
  localparam logic [16:0] SPEC_GAIN = 17'd60293;
  localparam logic [16:0] EMIS_GAIN = 17'd18350;
  localparam logic [16:0] HALF_Q    = 17'd32768;
  localparam logic [16:0] ROUGH_GAIN = 17'd88;
  localparam logic [6:0]  EXPO_MIN  = 7'd8;

  localparam logic signed [40:0] NUM_L_BIAS = 41'sd15011348480;
  localparam logic signed [40:0] NUM_H_BIAS = 41'sd19793182720;
  localparam logic [46:0] RAD_BIAS = 47'd27487790694400;

  localparam int STG_CAP   = 0;
  localparam int STG_MUL   = 1;
  localparam int STG_SUM   = 2;
  localparam int ISQ_FIRST = 3;
  localparam int ISQ_LAST  = 25;
  localparam int DIV_FIRST = 26;
  localparam int DIV_LAST  = 42;
  localparam int STG_DIFF  = 43;
  localparam int POW_FIRST = 44;
  localparam int POW_LAST  = 50;
  localparam int STG_SPEC  = 51;
  localparam int STG_COL   = 52;
  localparam int STG_PROD  = 53;
  localparam int STG_OUT   = 54;
  localparam int NUM_STG   = 55;

  typedef struct packed {
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic [6:0]         expo;
    logic [16:0]        specw;
    logic [2:0][15:0]   base;
    logic [15:0]        transp;
    logic [2:0][7:0]    bg;
    logic signed [33:0] mxx;
    logic signed [33:0] myy;
    logic signed [33:0] pxl;
    logic signed [33:0] pyl;
    logic signed [33:0] pxh;
    logic signed [33:0] pyh;
    logic [46:0]        rad;
    logic [46:0]        root;
    logic [39:0]        numl;
    logic [39:0]        numh;
    logic [16:0]        ql;
    logic [16:0]        qh;
    logic [16:0]        diff;
    logic [16:0]        pw_r;
    logic [16:0]        pw_b;
    logic [6:0]         pw_e;
    logic [16:0]        spec;
    logic [2:0][16:0]   col;
    logic [2:0][23:0]   pa;
    logic [2:0][41:0]   pb;
    logic [2:0][7:0]    shade;
  } pipe_t;

  function automatic logic [16:0] qmul(input logic [16:0] a, input logic [16:0] b);
    logic [34:0] p;
    p = 35'(a) * 35'(b) + 35'(HALF_Q);
    return p[32:16];
  endfunction

endpackage

// ===== rtl/sbp_in_if.sv =====
interface sbp_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] coord_u;
  logic [15:0] coord_v;
  logic [15:0] base_red;
  logic [15:0] base_green;
  logic [15:0] base_blue;
  logic [15:0] surface_roughness;
  logic [15:0] surface_reflectivity;
  logic [15:0] surface_transparency;
  logic [7:0]  back_red;
  logic [7:0]  back_green;
  logic [7:0]  back_blue;

  modport source (output valid, coord_u, coord_v, base_red, base_green, base_blue,
                  surface_roughness, surface_reflectivity, surface_transparency,
                  back_red, back_green, back_blue, input ready);
  modport sink (input valid, coord_u, coord_v, base_red, base_green, base_blue,
                surface_roughness, surface_reflectivity, surface_transparency,
                back_red, back_green, back_blue, output ready);
endinterface

// ===== rtl/sbp_out_if.sv =====
interface sbp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] shade_red;
  logic [7:0] shade_green;
  logic [7:0] shade_blue;

  modport source (output valid, shade_red, shade_green, shade_blue, input ready);
  modport sink (input valid, shade_red, shade_green, shade_blue, output ready);
endinterface

// ===== rtl/sbp_cfg_if.sv =====
interface sbp_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] emissive_level;

  modport source (output valid, emissive_level, input ready);
  modport sink (input valid, emissive_level, output ready);
endinterface

// ===== rtl/swatch_blinn_phong_shader.sv =====
// Throughput: one item per cycle while the output is ready; the 55-stage pipeline holds bubbles that
// a stalled output squeezes out, stage by stage.
// The root and the two quotients are one bit per stage, the power one
// square-and-multiply step per stage.
// Reset clears all stage valid bits and sets the emissive level to zero.
module swatch_blinn_phong_shader (
  input  logic clk,
  input  logic rst_n,
  sbp_in_if.sink    in_if,
  sbp_out_if.source out_if,
  sbp_cfg_if.sink   cfg_if
);

  localparam int NS = sbp_pkg::NUM_STG;

  sbp_pkg::pipe_t        p_r   [NS];
  sbp_pkg::pipe_t        p_nxt [NS];
  logic [NS-1:0]         v_r;
  logic [NS-1:0]         en;
  logic [16:0]           emis_r;

  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_if.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_if.ready  = en[0];
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = v_r[NS-1];
  assign out_if.shade_red   = p_r[NS-1].shade[0];
  assign out_if.shade_green = p_r[NS-1].shade[1];
  assign out_if.shade_blue  = p_r[NS-1].shade[2];

  always_comb begin
    sbp_pkg::pipe_t    s;
    logic [46:0]       b;
    logic [46:0]       rb;
    logic [39:0]       ds;
    logic signed [40:0] nl;
    logic signed [40:0] nh;
    logic [34:0]       sq;
    logic [16:0]       cl;
    logic [16:0]       chh;
    logic [17:0]       c;
    logic [24:0]       c255;
    logic [42:0]       sum;
    logic [10:0]       o;
    logic [33:0]       ex;
    b = '0;
    rb = '0;
    ds = '0;
    nl = '0;
    nh = '0;
    sq = '0;
    cl = '0;
    chh = '0;
    c = '0;
    c255 = '0;
    sum = '0;
    o = '0;
    ex = '0;
    for (int k = 0; k < NS; k++) begin
      if (k == sbp_pkg::STG_CAP) begin
        s = '0;
        s.dx = $signed({1'b0, in_if.coord_u}) - $signed({1'b0, sbp_pkg::HALF_Q[15:0]});
        s.dy = $signed({1'b0, in_if.coord_v}) - $signed({1'b0, sbp_pkg::HALF_Q[15:0]});
        ex = 34'(sbp_pkg::Q_ONE - {1'b0, in_if.surface_roughness})
             * 34'(sbp_pkg::ROUGH_GAIN) + 34'(sbp_pkg::HALF_Q);
        s.expo = sbp_pkg::EXPO_MIN + ex[22:16];
        s.specw = sbp_pkg::SPEC_BIAS
                  + sbp_pkg::qmul({1'b0, in_if.surface_reflectivity}, sbp_pkg::SPEC_GAIN);
        s.base[0] = in_if.base_red;
        s.base[1] = in_if.base_green;
        s.base[2] = in_if.base_blue;
        s.transp = in_if.surface_transparency;
        s.bg[0] = in_if.back_red;
        s.bg[1] = in_if.back_green;
        s.bg[2] = in_if.back_blue;
      end else begin
        s = p_r[k-1];
        if (k == sbp_pkg::STG_MUL) begin
          s.mxx = s.dx * s.dx;
          s.myy = s.dy * s.dy;
          s.pxl = s.dx * $signed(sbp_pkg::LX);
          s.pyl = s.dy * $signed(sbp_pkg::LY);
          s.pxh = s.dx * $signed(sbp_pkg::HX);
          s.pyh = s.dy * $signed(sbp_pkg::HY);
        end else if (k == sbp_pkg::STG_SUM) begin
          sq = 35'(s.mxx) + 35'(s.myy);
          s.rad = sbp_pkg::RAD_BIAS + (47'(sq[31:0]) << 14);
          s.root = '0;
          nl = sbp_pkg::NUM_L_BIAS - ((41'(s.pxl) + 41'(s.pyl)) <<< 3);
          nh = sbp_pkg::NUM_H_BIAS - ((41'(s.pxh) + 41'(s.pyh)) <<< 3);
          s.numl = (nl <= 0) ? '0 : {nl[35:0], 4'b0000};
          s.numh = (nh <= 0) ? '0 : {nh[35:0], 4'b0000};
          s.ql = '0;
          s.qh = '0;
        end else if (k >= sbp_pkg::ISQ_FIRST && k <= sbp_pkg::ISQ_LAST) begin
          b = 47'(1) << (2 * (sbp_pkg::ISQ_LAST - k));
          rb = s.root + b;
          if (s.rad >= rb) begin
            s.rad = s.rad - rb;
            s.root = (s.root >> 1) + b;
          end else begin
            s.root = s.root >> 1;
          end
        end else if (k >= sbp_pkg::DIV_FIRST && k <= sbp_pkg::DIV_LAST) begin
          ds = 40'(s.root) << (sbp_pkg::DIV_LAST - k);
          if (s.numl >= ds) begin
            s.numl = s.numl - ds;
            s.ql = s.ql | (17'(1) << (sbp_pkg::DIV_LAST - k));
          end
          if (s.numh >= ds) begin
            s.numh = s.numh - ds;
            s.qh = s.qh | (17'(1) << (sbp_pkg::DIV_LAST - k));
          end
        end else if (k == sbp_pkg::STG_DIFF) begin
          cl  = (s.ql > sbp_pkg::Q_ONE) ? sbp_pkg::Q_ONE : s.ql;
          chh = (s.qh > sbp_pkg::Q_ONE) ? sbp_pkg::Q_ONE : s.qh;
          s.diff = sbp_pkg::DIFF_BIAS + sbp_pkg::qmul(cl, sbp_pkg::DIFF_GAIN);
          s.pw_r = sbp_pkg::Q_ONE;
          s.pw_b = chh;
          s.pw_e = s.expo;
        end else if (k >= sbp_pkg::POW_FIRST && k <= sbp_pkg::POW_LAST) begin
          if (s.pw_e[0]) begin
            s.pw_r = sbp_pkg::qmul(s.pw_r, s.pw_b);
          end
          s.pw_b = sbp_pkg::qmul(s.pw_b, s.pw_b);
          s.pw_e = s.pw_e >> 1;
        end else if (k == sbp_pkg::STG_SPEC) begin
          s.spec = sbp_pkg::qmul(s.pw_r, s.specw);
        end else if (k == sbp_pkg::STG_COL) begin
          for (int ch = 0; ch < 3; ch++) begin
            c = 18'(sbp_pkg::qmul({1'b0, s.base[ch]}, s.diff)) + 18'(s.spec) + 18'(emis_r);
            s.col[ch] = (c > 18'(sbp_pkg::Q_ONE)) ? sbp_pkg::Q_ONE : c[16:0];
          end
        end else if (k == sbp_pkg::STG_PROD) begin
          for (int ch = 0; ch < 3; ch++) begin
            c255 = (25'(s.col[ch]) << 8) - 25'(s.col[ch]);
            s.pa[ch] = 24'(s.bg[ch]) * 24'(s.transp);
            s.pb[ch] = 42'(c255) * 42'(sbp_pkg::Q_ONE - {1'b0, s.transp});
          end
        end else if (k == sbp_pkg::STG_OUT) begin
          for (int ch = 0; ch < 3; ch++) begin
            sum = (43'(s.pa[ch]) << 16) + 43'(s.pb[ch]) + (43'(1) << 31);
            o = sum[42:32];
            s.shade[ch] = (o > 11'd255) ? 8'hFF : o[7:0];
          end
        end
      end
      p_nxt[k] = s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r    <= '0;
      emis_r <= '0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        emis_r <= sbp_pkg::qmul({1'b0, cfg_if.emissive_level}, sbp_pkg::EMIS_GAIN);
      end
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= (k == 0) ? in_if.valid : v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (en[k]) begin
        p_r[k] <= p_nxt[k];
      end
    end
  end

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> (&v_r))
    else $error("input stalled while the pipeline has a free stage");

  a_emis_load: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_if.valid && cfg_if.ready |=> emis_r ==
      sbp_pkg::qmul({1'b0, $past(cfg_if.emissive_level)}, sbp_pkg::EMIS_GAIN))
    else $error("emissive term not loaded from the written level");

  a_diff_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[sbp_pkg::STG_DIFF] |-> p_r[sbp_pkg::STG_DIFF].diff <= sbp_pkg::Q_ONE)
    else $error("diffuse term above one");

  a_pow_done: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[sbp_pkg::POW_LAST] |-> p_r[sbp_pkg::POW_LAST].pw_e == 7'd0)
    else $error("exponent not consumed at the end of the power stages");

endmodule
